// ===== hw/rtl/wfrc_pkg.sv =====
// Shared types and constants for the wildcard filtered record counter.
// Used by the record RAM, the match unit and the top level; no dependencies.
`default_nettype none

package wfrc_pkg;

  localparam int RECORD_DEPTH = 1024;
  localparam int ADDR_W       = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int TOTAL_W      = $clog2(RECORD_DEPTH + 1);
  localparam int COUNT_W      = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_EQUAL    = 2'd1,
    ACT_AT_LEAST = 2'd2,
    ACT_AT_MOST  = 2'd3
  } action_t;

  typedef struct packed {
    logic [2:0]  key_first;
    logic [3:0]  key_second;
    logic [4:0]  key_third;
    logic [1:0]  key_fourth;
    logic [15:0] value;
  } record_t;

  localparam int RECORD_W = $bits(record_t);

  typedef struct packed {
    action_t action;
    record_t keys;
  } query_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wildcard_filtered_record_count.sv =====
// Wildcard filtered record counter: insert items fill the store, queries count matches.
// Sequencing: an insert goes from ST_IDLE to ST_FINISH, which raises m_tvalid; a query scans one
// record a cycle through the RAM read port in ST_SCAN and then raises m_tvalid from ST_FINISH.
// Throughput: one item at a time, tready only while idle, so no new item is taken until the
// result is issued; a held result stalls the sequencer.
// Reset (rst, synchronous) clears the record count and sequencer; store needs no clearing.
`default_nettype none

module wildcard_filtered_record_count (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // key_first[2:0], key_second[6:3], key_third[11:7], key_fourth[13:12], value[29:14]
  input  wire logic [wfrc_pkg::S_TDATA_W-1:0] s_tdata,
  // action[1:0]
  input  wire logic [1:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // match_count[10:0]
  output logic [wfrc_pkg::M_TDATA_W-1:0]     m_tdata,
  // store_full[0]
  output logic                               m_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                           state;
  logic [wfrc_pkg::TOTAL_W-1:0]     total;
  logic [wfrc_pkg::TOTAL_W-1:0]     issue;
  logic                             rd_pend;
  logic [wfrc_pkg::COUNT_W-1:0]     count;
  logic                             full_flag;
  wfrc_pkg::query_t                 query;

  wfrc_pkg::record_t                in_rec;
  wfrc_pkg::record_t                rd_rec;
  logic                             accept;
  logic                             room;
  logic                             wr_en;
  logic                             issuing;
  logic                             hit;

  always_comb begin
    in_rec.key_first  = s_tdata[2:0];
    in_rec.key_second = s_tdata[6:3];
    in_rec.key_third  = s_tdata[11:7];
    in_rec.key_fourth = s_tdata[13:12];
    in_rec.value      = s_tdata[29:14];
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign room     = (total < wfrc_pkg::TOTAL_W'(wfrc_pkg::RECORD_DEPTH));
  assign wr_en    = accept && (wfrc_pkg::action_t'(s_tuser) == wfrc_pkg::ACT_INSERT) && room;
  assign issuing  = (state == ST_SCAN) && (issue < total);

  wfrc_record_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (total[wfrc_pkg::ADDR_W-1:0]),
    .wr_data (in_rec),
    .rd_addr (issue[wfrc_pkg::ADDR_W-1:0]),
    .rd_data (rd_rec)
  );

  wfrc_match_unit u_match (
    .rec   (rd_rec),
    .query (query),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      issue     <= '0;
      rd_pend   <= 1'b0;
      count     <= '0;
      full_flag <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            count   <= '0;
            issue   <= '0;
            rd_pend <= 1'b0;
            query   <= '{action: wfrc_pkg::action_t'(s_tuser), keys: in_rec};
            if (wfrc_pkg::action_t'(s_tuser) == wfrc_pkg::ACT_INSERT) begin
              full_flag <= !room;
              if (room) begin
                total <= total + 1'b1;
              end
              state <= ST_FINISH;
            end else begin
              full_flag <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= issuing;
          if (issuing) begin
            issue <= issue + 1'b1;
          end
          if (rd_pend && hit && count != wfrc_pkg::COUNT_MAX) begin
            count <= count + 1'b1;
          end
          if (!issuing && !rd_pend) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(wfrc_pkg::M_TDATA_W - wfrc_pkg::COUNT_W){1'b0}}, count};
            m_tuser  <= full_flag;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wfrc_record_ram.sv =====
// Record store: one write port, one read port with registered read data.
// Depends on wfrc_pkg for depth and record layout.
`default_nettype none

module wfrc_record_ram (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [wfrc_pkg::ADDR_W-1:0] wr_addr,
  input  wire wfrc_pkg::record_t          wr_data,
  input  wire logic [wfrc_pkg::ADDR_W-1:0] rd_addr,
  output wfrc_pkg::record_t               rd_data
);

  wfrc_pkg::record_t mem [wfrc_pkg::RECORD_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wfrc_match_unit.sv =====
// Shared compare unit: tests one stored record against the held query.
// Depends on wfrc_pkg for the record and query types.
`default_nettype none

module wfrc_match_unit (
  input  wire wfrc_pkg::record_t rec,
  input  wire wfrc_pkg::query_t  query,
  output logic                   hit
);

  logic keys_ok;
  logic value_ok;

  always_comb begin
    keys_ok = (query.keys.key_first  == '0 || query.keys.key_first  == rec.key_first)  &&
              (query.keys.key_second == '0 || query.keys.key_second == rec.key_second) &&
              (query.keys.key_third  == '0 || query.keys.key_third  == rec.key_third)  &&
              (query.keys.key_fourth == '0 || query.keys.key_fourth == rec.key_fourth);
    unique case (query.action)
      wfrc_pkg::ACT_EQUAL:    value_ok = (rec.value == query.keys.value);
      wfrc_pkg::ACT_AT_LEAST: value_ok = (rec.value >= query.keys.value);
      wfrc_pkg::ACT_AT_MOST:  value_ok = (rec.value <= query.keys.value);
      default:                value_ok = 1'b0;
    endcase
    hit = keys_ok && value_ok;
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for wildcard_filtered_record_count: stream driver, result monitor
// and a record-store predictor that counts matches per query. Needs wfrc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned CALM_ITEMS  = 40;

  typedef struct {
    wfrc_pkg::query_t q;
    int unsigned      idle_pct;
  } stim_t;

  typedef struct {
    logic [wfrc_pkg::COUNT_W-1:0] match_count;
    logic                         store_full;
  } outcome_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [wfrc_pkg::S_TDATA_W-1:0] s_tdata;
  logic [1:0]                     s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [wfrc_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           m_tuser;

  stim_t             pending[$];
  outcome_t          expected[$];
  wfrc_pkg::record_t records[$];
  stim_t             cur_item;
  wfrc_pkg::query_t  seen;
  outcome_t          want;
  int unsigned       err_count;
  int unsigned       cycles;
  int unsigned       in_gap;
  int unsigned       out_gap;
  int unsigned       out_idle;
  int unsigned       seg_idle;
  int unsigned       n_items;
  bit                in_taken;
  bit                calm;

  wildcard_filtered_record_count u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic wfrc_pkg::record_t mk_record(int unsigned k1, int unsigned k2,
                                                  int unsigned k3, int unsigned k4,
                                                  int unsigned v);
    wfrc_pkg::record_t r;
    r.key_first  = k1[2:0];
    r.key_second = k2[3:0];
    r.key_third  = k3[4:0];
    r.key_fourth = k4[1:0];
    r.value      = v[15:0];
    return r;
  endfunction

  // store inserts, count matching records for queries
  function automatic outcome_t apply_item(wfrc_pkg::action_t act, wfrc_pkg::record_t k);
    outcome_t o;
    bit       hit;
    o.match_count = '0;
    o.store_full  = 1'b0;
    if (act == wfrc_pkg::ACT_INSERT) begin
      if (records.size() < wfrc_pkg::RECORD_DEPTH) records.push_back(k);
      else o.store_full = 1'b1;
    end else begin
      foreach (records[i]) begin
        hit = (k.key_first  == 0 || k.key_first  == records[i].key_first)  &&
              (k.key_second == 0 || k.key_second == records[i].key_second) &&
              (k.key_third  == 0 || k.key_third  == records[i].key_third)  &&
              (k.key_fourth == 0 || k.key_fourth == records[i].key_fourth);
        case (act)
          wfrc_pkg::ACT_EQUAL:    hit = hit && (records[i].value == k.value);
          wfrc_pkg::ACT_AT_LEAST: hit = hit && (records[i].value >= k.value);
          default:                hit = hit && (records[i].value <= k.value);
        endcase
        if (hit && o.match_count != wfrc_pkg::COUNT_MAX) o.match_count++;
      end
    end
    return o;
  endfunction

  task automatic push_item(wfrc_pkg::action_t act, wfrc_pkg::record_t r);
    stim_t s;
    if (n_items % 60 == 0) begin
      case ($urandom_range(0, 2))
        0:       seg_idle = 0;
        1:       seg_idle = 15;
        default: seg_idle = 40;
      endcase
    end
    s.q.action = act;
    s.q.keys   = r;
    s.idle_pct = calm ? 0 : seg_idle;
    pending.push_back(s);
    n_items++;
  endtask

  function automatic int unsigned pick_key(int unsigned maxv);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, maxv);
    return $urandom_range(0, 2);
  endfunction

  function automatic int unsigned pick_value();
    int unsigned pool[7] = '{0, 1, 2, 100, 32768, 65534, 65535};
    case ($urandom_range(0, 3))
      0:       return pool[$urandom_range(0, 6)];
      1:       return $urandom_range(0, 15);
      default: return $urandom & 16'hFFFF;
    endcase
  endfunction

  task automatic rand_item(int unsigned insert_pct);
    wfrc_pkg::action_t act;
    if ($urandom_range(0, 99) < insert_pct) act = wfrc_pkg::ACT_INSERT;
    else act = wfrc_pkg::action_t'($urandom_range(1, 3));
    push_item(act, mk_record(pick_key(7), pick_key(15), pick_key(31), pick_key(3),
                             pick_value()));
  endtask

  // stimulus
  initial begin : stimulus
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    calm     = 1'b0;
    seg_idle = 0;

    // empty store
    push_item(wfrc_pkg::ACT_EQUAL,    mk_record(0, 0, 0, 0, 0));
    push_item(wfrc_pkg::ACT_AT_LEAST, mk_record(0, 0, 0, 0, 0));
    push_item(wfrc_pkg::ACT_AT_MOST,  mk_record(0, 0, 0, 0, 65535));
    // extremes, zero keys, shared values
    push_item(wfrc_pkg::ACT_INSERT,   mk_record(7, 15, 31, 3, 65535));
    push_item(wfrc_pkg::ACT_INSERT,   mk_record(0, 0, 0, 0, 0));
    push_item(wfrc_pkg::ACT_INSERT,   mk_record(1, 1, 1, 1, 100));
    push_item(wfrc_pkg::ACT_INSERT,   mk_record(2, 5, 17, 2, 100));
    push_item(wfrc_pkg::ACT_INSERT,   mk_record(7, 15, 31, 3, 0));
    push_item(wfrc_pkg::ACT_EQUAL,    mk_record(0, 0, 0, 0, 100));
    push_item(wfrc_pkg::ACT_AT_LEAST, mk_record(0, 0, 0, 0, 0));
    push_item(wfrc_pkg::ACT_AT_MOST,  mk_record(0, 0, 0, 0, 65535));
    push_item(wfrc_pkg::ACT_AT_MOST,  mk_record(0, 0, 0, 0, 0));
    push_item(wfrc_pkg::ACT_AT_LEAST, mk_record(0, 0, 0, 0, 65535));
    push_item(wfrc_pkg::ACT_EQUAL,    mk_record(7, 0, 0, 0, 65535));
    push_item(wfrc_pkg::ACT_AT_MOST,  mk_record(7, 15, 31, 3, 65535));
    push_item(wfrc_pkg::ACT_EQUAL,    mk_record(0, 1, 0, 0, 100));
    push_item(wfrc_pkg::ACT_EQUAL,    mk_record(0, 0, 0, 0, 0));
    push_item(wfrc_pkg::ACT_EQUAL,    mk_record(1, 0, 0, 0, 0));
    push_item(wfrc_pkg::ACT_AT_LEAST, mk_record(0, 0, 17, 2, 99));
    push_item(wfrc_pkg::ACT_AT_MOST,  mk_record(2, 5, 17, 2, 100));

    repeat (520) rand_item(35);
    calm = 1'b1;
    repeat (CALM_ITEMS) rand_item(30);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_tvalid || expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken || !s_tvalid) begin
        if (in_gap != 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur_item = pending.pop_front();
          s_tdata  <= {2'b00, cur_item.q.keys.value, cur_item.q.keys.key_fourth,
                       cur_item.q.keys.key_third, cur_item.q.keys.key_second,
                       cur_item.q.keys.key_first};
          s_tuser  <= cur_item.q.action;
          s_tvalid <= 1'b1;
          out_idle = cur_item.idle_pct;
          if ($urandom_range(0, 99) < cur_item.idle_pct) in_gap = $urandom_range(1, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      in_taken = 1'b0;

      if (out_gap != 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle) begin
        out_gap = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: sample on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.action          = wfrc_pkg::action_t'(s_tuser);
        seen.keys.key_first  = s_tdata[2:0];
        seen.keys.key_second = s_tdata[6:3];
        seen.keys.key_third  = s_tdata[11:7];
        seen.keys.key_fourth = s_tdata[13:12];
        seen.keys.value      = s_tdata[29:14];
        expected.push_back(apply_item(seen.action, seen.keys));
        in_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, actual count %0d full %0b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected.pop_front();
          if (m_tdata !== wfrc_pkg::M_TDATA_W'(want.match_count)) begin
            err_count++;
            $display("%0t: match_count mismatch: expected %0d, actual %0d",
                     $time, want.match_count, m_tdata);
          end
          if (m_tuser !== want.store_full) begin
            err_count++;
            $display("%0t: store_full mismatch: expected %0b, actual %0b",
                     $time, want.store_full, m_tuser);
          end
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
